// ----- rtl/kcl_pkg.sv -----
// Shared constants, types and the character class table of the keyword lexer.
package kcl_pkg;

   localparam int KwSlots    = 16;
   localparam int KwLen      = 16;
   localparam int SlotW      = $clog2(KwSlots);
   localparam int CountW     = $clog2(KwSlots + 1);
   localparam int LenW       = $clog2(KwLen + 1);
   localparam int PosW       = $clog2(KwLen);
   localparam int FillW      = $clog2(KwLen + 1);
   localparam int RowW       = 8 * KwLen;
   localparam int ClassW     = 14;
   localparam int OffW       = 16;
   localparam int ReqDataW   = 24;
   localparam int RspDataW   = 40;

   localparam logic [ClassW-1:0] ClNull    = 14'h0001;
   localparam logic [ClassW-1:0] ClWs      = 14'h0002;
   localparam logic [ClassW-1:0] ClTab     = 14'h0004;
   localparam logic [ClassW-1:0] ClNl      = 14'h0008;
   localparam logic [ClassW-1:0] ClCr      = 14'h0010;
   localparam logic [ClassW-1:0] ClSymbol  = 14'h0020;
   localparam logic [ClassW-1:0] ClQuote   = 14'h0040;
   localparam logic [ClassW-1:0] ClParen   = 14'h0080;
   localparam logic [ClassW-1:0] ClDigit   = 14'h0100;
   localparam logic [ClassW-1:0] ClAlpha   = 14'h0200;
   localparam logic [ClassW-1:0] ClUpper   = 14'h0400;
   localparam logic [ClassW-1:0] ClLower   = 14'h0800;
   localparam logic [ClassW-1:0] ClWord    = 14'h1000;
   localparam logic [ClassW-1:0] ClUnknown = 14'h2000;

   localparam logic ActSource  = 1'b0;
   localparam logic ActKeyword = 1'b1;

   // One token on its way to the result port.
   typedef struct packed {
      logic [ClassW-1:0] cls;
      logic [OffW-1:0]   start;
      logic [LenW-1:0]   len;
   } token_type;

   // Class mask of a single source byte.
   function automatic logic [ClassW-1:0] byte_class(input logic [7:0] c);
      logic [ClassW-1:0] r;
      r = '0;
      if (c >= 8'd128) r = ClUnknown;
      else if (c == 8'd0) r = ClNull;
      else if (c == 8'd9) r = ClWs | ClTab;
      else if (c == 8'd10) r = ClWs | ClNl;
      else if (c == 8'd13) r = ClWs | ClCr;
      else if (c == 8'd32) r = ClWs;
      else if (c == 8'h22 || c == 8'h27) r = ClQuote;
      else if (c >= 8'h30 && c <= 8'h39) r = ClDigit;
      else if (c >= 8'h41 && c <= 8'h5A) r = ClAlpha | ClUpper;
      else if (c >= 8'h61 && c <= 8'h7A) r = ClAlpha | ClLower;
      else if (c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
               c == 8'h7B || c == 8'h7D) r = ClSymbol | ClParen;
      else if (c > 8'd32 && c < 8'd127) r = ClSymbol;
      return r;
   endfunction

endpackage

// ----- rtl/kcl_ram.sv -----
// Generic single-port-write, registered-read RAM.
module kcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/keyword_and_char_class_lexer.sv -----
// Top level of the keyword and character class lexer.
//
//  channel  direction  handshake               contents
//  req_     in         tvalid/tready           tuser action, tlast end_of_source, tdata
//  rsp_     out        tvalid/tready           tlast last_token, tdata token fields
//  csr_     in         valid/ready             keyword_count
//
// A keyword write reads, modifies and writes back one keyword row.
// A source byte is stored in the window, followed by one decision when the window is
// full; the final byte decides every byte still in the window. A decision tries one keyword
// slot per cycle through the keyword row memory; a byte covered by a matched keyword
// is skipped without a search.
// Reset is synchronous; keyword lengths reset to one, keyword bytes are undefined.
// A stalled result port holds the lexer in its emit states.
module keyword_and_char_class_lexer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,   // action
   input  logic                            req_tlast,   // end_of_source
   // byte_value[7:0], word_slot[11:8], char_pos[15:12], word_length[20:16]
   input  logic [kcl_pkg::ReqDataW-1:0]    req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic                            rsp_tlast,   // last_token
   // token_class[13:0], token_start[29:14], token_length[34:30]
   output logic [kcl_pkg::RspDataW-1:0]    rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kcl_pkg::CountW-1:0]      csr_data
);
   import kcl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_KW_RD, S_KW_WR, S_DECIDE, S_SEARCH, S_EMIT, S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         win_ff [KwLen];
   logic [7:0]         win_in [KwLen];
   logic [FillW-1:0]   fill_ff, fill_in;
   logic [OffW-1:0]    pos_ff, pos_in;
   logic [LenW-1:0]    skip_ff, skip_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [LenW-1:0]    lens_ff [KwSlots];
   logic [LenW-1:0]    lens_in [KwSlots];
   logic               eos_ff, eos_in;
   logic [SlotW-1:0]   kw_slot_ff, kw_slot_in;
   logic [PosW-1:0]    kw_pos_ff, kw_pos_in;
   logic [7:0]         kw_byte_ff, kw_byte_in;
   logic [CountW-1:0]  issue_ff, issue_in;
   logic               tag_vld_ff, tag_vld_in;
   logic [SlotW-1:0]   tag_slot_ff, tag_slot_in;
   token_type          tok_ff, tok_in;
   token_type          pend_ff, pend_in;
   logic               pend_vld_ff, pend_vld_in;
   token_type          out_ff, out_in;
   logic               out_last_ff, out_last_in;
   logic               out_vld_ff, out_vld_in;

   logic               ram_we;
   logic [SlotW-1:0]   ram_rd_addr;
   logic [RowW-1:0]    ram_wr_row;
   logic [RowW-1:0]    ram_rd_row;
   logic               out_free;
   logic               match;
   logic [LenW-1:0]    tag_len;
   logic [LenW-1:0]    wlen_sat;
   logic [CountW-1:0]  csr_sat;
   logic [PosW-1:0]    ins_idx;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0, out_ff.len, out_ff.start, out_ff.cls};
   assign out_free   = !out_vld_ff || rsp_tready;

   assign wlen_sat = (req_tdata[20:16] > LenW'(KwLen)) ? LenW'(KwLen) : req_tdata[20:16];
   assign csr_sat  = (csr_data > CountW'(KwSlots)) ? CountW'(KwSlots) : csr_data;
   assign ins_idx  = (fill_ff >= FillW'(KwLen)) ? PosW'(KwLen - 1) : fill_ff[PosW-1:0];

   // Keyword rows: one row of bytes per slot.
   assign ram_rd_addr = (state_ff == S_SEARCH) ? issue_ff[SlotW-1:0] : kw_slot_ff;
   assign ram_we      = (state_ff == S_KW_WR);
   always_comb begin
      ram_wr_row = ram_rd_row;
      ram_wr_row[kw_pos_ff*8 +: 8] = kw_byte_ff;
   end

   kcl_ram #(.WIDTH(RowW), .DEPTH(KwSlots)) u_rows (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (kw_slot_ff),
      .wr_data (ram_wr_row),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_row)
   );

   // Compare the window head against the keyword row that has just been read.
   assign tag_len = lens_ff[tag_slot_ff];
   always_comb begin
      match = (tag_len != '0) && (tag_len <= fill_ff);
      for (int k = 0; k < KwLen; k++) begin
         if (LenW'(k) < tag_len && win_ff[k] != ram_rd_row[k*8 +: 8]) match = 1'b0;
      end
   end

   // Sequencer and all next values.
   always_comb begin
      state_in    = state_ff;
      win_in      = win_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      skip_in     = skip_ff;
      count_in    = count_ff;
      lens_in     = lens_ff;
      eos_in      = eos_ff;
      kw_slot_in  = kw_slot_ff;
      kw_pos_in   = kw_pos_ff;
      kw_byte_in  = kw_byte_ff;
      issue_in    = issue_ff;
      tag_vld_in  = 1'b0;
      tag_slot_in = tag_slot_ff;
      tok_in      = tok_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;

      if (csr_valid) count_in = csr_sat;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ActKeyword) begin
                  kw_slot_in = req_tdata[11:8];
                  kw_pos_in  = req_tdata[15:12];
                  kw_byte_in = req_tdata[7:0];
                  lens_in[req_tdata[11:8]] = wlen_sat;
                  state_in   = S_KW_RD;
               end else begin
                  win_in[ins_idx] = req_tdata[7:0];
                  fill_in = FillW'(ins_idx) + FillW'(1);
                  pos_in  = pos_ff + OffW'(1);
                  eos_in  = req_tlast;
                  if (req_tlast || (FillW'(ins_idx) + FillW'(1)) == FillW'(KwLen))
                     state_in = S_DECIDE;
               end
            end
         end
         S_KW_RD: state_in = S_KW_WR;
         S_KW_WR: state_in = S_IDLE;
         S_DECIDE: begin
            if (fill_ff == '0) begin
               state_in = S_FINISH;
            end else if (skip_ff != '0) begin
               skip_in = skip_ff - LenW'(1);
               for (int i = 0; i < KwLen - 1; i++) win_in[i] = win_ff[i+1];
               fill_in  = fill_ff - FillW'(1);
               state_in = eos_ff ? S_DECIDE : S_IDLE;
            end else begin
               issue_in = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            tag_vld_in  = (issue_ff < count_ff);
            tag_slot_in = issue_ff[SlotW-1:0];
            issue_in    = issue_ff + CountW'(1);
            if ((tag_vld_ff && match) || (!tag_vld_ff && issue_ff >= count_ff)) begin
               tag_vld_in   = 1'b0;
               tok_in.start = pos_ff - OffW'(fill_ff);
               if (tag_vld_ff && match) begin
                  tok_in.cls = ClWord;
                  tok_in.len = tag_len;
               end else begin
                  tok_in.cls = byte_class(win_ff[0]);
                  tok_in.len = LenW'(1);
               end
               skip_in = (tag_vld_ff && match) ? tag_len - LenW'(1) : '0;
               for (int i = 0; i < KwLen - 1; i++) win_in[i] = win_ff[i+1];
               fill_in  = fill_ff - FillW'(1);
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (eos_ff) begin
               // During a flush the newest token waits so that the last can be marked.
               if (!pend_vld_ff || out_free) begin
                  if (pend_vld_ff) begin
                     out_in      = pend_ff;
                     out_last_in = 1'b0;
                     out_vld_in  = 1'b1;
                  end
                  pend_in     = tok_ff;
                  pend_vld_in = 1'b1;
                  state_in    = S_DECIDE;
               end
            end else if (out_free) begin
               out_in      = tok_ff;
               out_last_in = 1'b0;
               out_vld_in  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FINISH: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_in      = pend_ff;
                  out_last_in = 1'b1;
                  out_vld_in  = 1'b1;
               end
               pend_vld_in = 1'b0;
               fill_in     = '0;
               pos_in      = '0;
               skip_in     = '0;
               eos_in      = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         pos_ff      <= '0;
         skip_ff     <= '0;
         count_ff    <= '0;
         eos_ff      <= 1'b0;
         tag_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         issue_ff    <= '0;
         for (int s = 0; s < KwSlots; s++) lens_ff[s] <= LenW'(1);
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         count_ff    <= count_in;
         eos_ff      <= eos_in;
         tag_vld_ff  <= tag_vld_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         issue_ff    <= issue_in;
         lens_ff     <= lens_in;
      end
      win_ff      <= win_in;
      kw_slot_ff  <= kw_slot_in;
      kw_pos_ff   <= kw_pos_in;
      kw_byte_ff  <= kw_byte_in;
      tag_slot_ff <= tag_slot_in;
      tok_ff      <= tok_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- bench/keyword_and_char_class_lexer_tb.sv -----
// Self-checking testbench of the keyword and character class lexer.
module keyword_and_char_class_lexer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kcl_pkg::*;

   localparam int SettleCycles = 60;
   localparam int StallLimit   = 3000;
   localparam int ItemTarget   = 410;

   typedef enum logic [1:0] {RowSource, RowKeyword, RowCount} row_kind_type;

   // One row of the directed stimulus.
   typedef struct {
      row_kind_type       kind;
      logic [7:0]         value;
      logic               eos;
      logic [SlotW-1:0]   slot;
      logic [PosW-1:0]    pos;
      logic [4:0]         wlen;
      logic               has_cls;
      logic [ClassW-1:0]  cls;
   } stim_row_type;

   // One token as the lexer should emit it.
   typedef struct {
      logic [ClassW-1:0] cls;
      logic [OffW-1:0]   start;
      logic [LenW-1:0]   len;
      logic              last;
   } lex_token_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = ActSource;
   logic                  req_tlast = 1'b0;
   logic [ReqDataW-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tlast;
   logic [RspDataW-1:0]   rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CountW-1:0]     csr_data = '0;

   // Predictor state.
   logic [7:0]            win_bytes [KwLen];
   int unsigned           win_fill;
   logic [7:0]            kw_bytes [KwSlots][KwLen];
   int unsigned           kw_length [KwSlots];
   logic [KwLen-1:0]      kw_written [KwSlots];
   logic [OffW-1:0]       src_pos;
   int unsigned           skip_left;
   int unsigned           active_slots;

   lex_token_type         pending_tokens [$];
   int                    errors = 0;
   int                    items_sent = 0;
   int                    tokens_seen = 0;
   int                    words_seen = 0;
   int                    kw_writes = 0;
   int                    sources_done = 0;
   int                    idle_cycles = 0;
   bit                    quiet = 1'b0;
   int                    rsp_hold = 0;

   keyword_and_char_class_lexer u_dut (.*);

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // Class mask of a single byte, as the fixed ASCII table gives it.
   function automatic logic [ClassW-1:0] ascii_class(input logic [7:0] c);
      if (c >= 8'd128) return ClUnknown;
      case (c)
         8'd0:  return ClNull;
         8'd9:  return ClWs | ClTab;
         8'd10: return ClWs | ClNl;
         8'd13: return ClWs | ClCr;
         8'd32: return ClWs;
         "\"", "'": return ClQuote;
         "(", ")", "[", "]", "{", "}": return ClSymbol | ClParen;
         default: ;
      endcase
      if (c >= "0" && c <= "9") return ClDigit;
      if (c >= "A" && c <= "Z") return ClAlpha | ClUpper;
      if (c >= "a" && c <= "z") return ClAlpha | ClLower;
      if (c > 8'd32 && c < 8'd127) return ClSymbol;
      return '0;
   endfunction

   // Decides the head of the window; returns 1 when a token was queued.
   function automatic int decide_head();
      lex_token_type tok;
      bit found;
      bit same;
      int unsigned kl;
      int made;
      if (win_fill == 0) return 0;
      made = 0;
      tok.start = src_pos - OffW'(win_fill);
      tok.last = 1'b0;
      if (skip_left > 0) begin
         skip_left--;
      end else begin
         found = 1'b0;
         tok.len = LenW'(1);
         for (int s = 0; s < active_slots && !found; s++) begin
            kl = kw_length[s];
            if (kl == 0 || kl > win_fill) continue;
            same = 1'b1;
            for (int k = 0; k < kl; k++)
               if (win_bytes[k] != kw_bytes[s][k]) same = 1'b0;
            if (same) begin
               found = 1'b1;
               tok.len = LenW'(kl);
            end
         end
         tok.cls = found ? ClWord : ascii_class(win_bytes[0]);
         skip_left = tok.len - 1;
         pending_tokens.push_back(tok);
         made = 1;
      end
      for (int k = 0; k < KwLen - 1; k++) win_bytes[k] = win_bytes[k+1];
      win_fill--;
      return made;
   endfunction

   // Works out the tokens caused by one accepted input word.
   function automatic int predict_tokens(input logic act, input logic [7:0] value,
                                         input logic eos, input logic [SlotW-1:0] slot,
                                         input logic [PosW-1:0] pos, input logic [4:0] wlen);
      int n;
      n = 0;
      if (act == ActKeyword) begin
         kw_bytes[slot][pos] = value;
         kw_written[slot][pos] = 1'b1;
         kw_length[slot] = (wlen > KwLen) ? KwLen : wlen;
         return 0;
      end
      if (win_fill >= KwLen) win_fill = KwLen - 1;
      win_bytes[win_fill] = value;
      win_fill++;
      src_pos++;
      if (!eos) begin
         if (win_fill == KwLen) n = decide_head();
         return n;
      end
      while (win_fill > 0 && n < KwLen) n += decide_head();
      if (n > 0) pending_tokens[$].last = 1'b1;
      win_fill = 0;
      src_pos = '0;
      skip_left = 0;
      return n;
   endfunction

   // Number of leading written bytes of a slot.
   function automatic int unsigned written_prefix(input int s);
      int unsigned p;
      p = 0;
      while (p < KwLen && kw_written[s][p]) p++;
      return p;
   endfunction

   // Number of leading slots whose keyword bytes are all written.
   function automatic int unsigned usable_slots();
      int unsigned v;
      v = 0;
      while (v < KwSlots && kw_length[v] <= written_prefix(v)) v++;
      return v;
   endfunction

   function automatic int gap_length();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Sends one input word and predicts its tokens on acceptance. The word stays
   // driven until the caller sends the next one or drops the valid.
   task automatic send_word(input logic act, input logic [7:0] value, input logic eos,
                            input logic [SlotW-1:0] slot, input logic [PosW-1:0] pos,
                            input logic [4:0] wlen, output int made);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tlast  <= eos;
      req_tdata  <= {3'b0, wlen, pos, slot, value};
      do @(posedge clock); while (!req_tready);
      made = predict_tokens(act, value, eos, slot, pos, wlen);
      items_sent++;
      if (act == ActKeyword) kw_writes++;
      else if (eos) sources_done++;
      @(negedge clock);
   endtask

   // Waits until every token has arrived and the lexer has settled, then writes the count.
   task automatic write_count(input logic [CountW-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      active_slots = (value > KwSlots) ? KwSlots : value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Keyword bytes come mostly from a small alphabet so that the source hits them.
   function automatic logic [7:0] lex_byte();
      logic [7:0] pick [4];
      pick = '{"a", "b", "(", " "};
      if ($urandom_range(0, 99) < 82) return pick[$urandom_range(0, 3)];
      return 8'($urandom);
   endfunction

   // Keyword write whose length never reaches beyond the bytes written so far.
   task automatic random_keyword_write();
      int s;
      int p;
      int unsigned pre;
      logic [4:0] wlen;
      int made;
      s = $urandom_range(0, KwSlots - 1);
      pre = written_prefix(s);
      p = (pre < KwLen && $urandom_range(0, 99) < 75) ? pre : $urandom_range(0, KwLen - 1);
      if (p == pre && pre < KwLen) pre++;
      if (pre == 0 || $urandom_range(0, 99) < 4) wlen = 0;
      else if (pre == KwLen && $urandom_range(0, 99) < 30) wlen = 5'($urandom_range(16, 31));
      else wlen = 5'($urandom_range(1, pre > 4 && $urandom_range(0, 1) ? 4 : pre));
      send_word(ActKeyword, lex_byte(), 1'b0, SlotW'(s), PosW'(p), wlen, made);
   endtask

   // Result side: ready with random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 99) < 25)
            rsp_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(1, 3);
      end
   end

   // Compare each accepted result word with the oldest expected token.
   always @(posedge clock) begin
      lex_token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         tokens_seen++;
         if (pending_tokens.size() == 0) begin
            report("unexpected token", rsp_tdata, 0);
         end else begin
            want = pending_tokens.pop_front();
            if (want.cls == ClWord) words_seen++;
            if (rsp_tdata[13:0] !== want.cls) report("token_class", rsp_tdata[13:0], want.cls);
            if (rsp_tdata[29:14] !== want.start)
               report("token_start", rsp_tdata[29:14], want.start);
            if (rsp_tdata[34:30] !== want.len) report("token_length", rsp_tdata[34:30], want.len);
            if (rsp_tlast !== want.last) report("last_token", rsp_tlast, want.last);
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("keyword_and_char_class_lexer: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus.
   initial begin
      stim_row_type rows [$];
      int made;
      int src_len;
      int unsigned v;
      logic [CountW-1:0] cnt;

      for (int s = 0; s < KwSlots; s++) begin
         kw_length[s] = 1;
         kw_written[s] = '0;
      end
      win_fill = 0;
      src_pos = '0;
      skip_left = 0;
      active_slots = 0;

      // Single bytes over the class table, each a source of its own; then two
      // keywords, one of them of length zero, tried on a short source.
      rows = '{
         '{RowSource, 8'h00, 1, 0, 0, 1, 1, ClNull},
         '{RowSource, 8'h09, 1, 0, 0, 1, 1, ClWs | ClTab},
         '{RowSource, 8'h0A, 1, 0, 0, 1, 1, ClWs | ClNl},
         '{RowSource, 8'h0D, 1, 0, 0, 1, 1, ClWs | ClCr},
         '{RowSource, 8'h20, 1, 0, 0, 1, 1, ClWs},
         '{RowSource, 8'h22, 1, 0, 0, 1, 1, ClQuote},
         '{RowSource, 8'h28, 1, 0, 0, 1, 1, ClSymbol | ClParen},
         '{RowSource, 8'h21, 1, 0, 0, 1, 1, ClSymbol},
         '{RowSource, 8'h30, 1, 0, 0, 1, 1, ClDigit},
         '{RowSource, 8'h41, 1, 0, 0, 1, 1, ClAlpha | ClUpper},
         '{RowSource, 8'h61, 1, 0, 0, 1, 1, ClAlpha | ClLower},
         '{RowSource, 8'h01, 1, 0, 0, 1, 1, 14'h0},
         '{RowSource, 8'h7F, 1, 0, 0, 1, 1, 14'h0},
         '{RowSource, 8'h80, 1, 0, 0, 1, 1, ClUnknown},
         '{RowSource, 8'hFF, 1, 0, 0, 1, 1, ClUnknown},
         '{RowKeyword, "a", 0, 0, 0, 1, 0, 0},
         '{RowKeyword, "b", 0, 0, 1, 2, 0, 0},
         '{RowKeyword, "a", 0, 1, 0, 0, 0, 0},
         '{RowCount, 8'd2, 0, 0, 0, 0, 0, 0},
         '{RowSource, "a", 0, 0, 0, 0, 0, 0},
         '{RowSource, "b", 0, 0, 0, 0, 0, 0},
         '{RowSource, "a", 0, 0, 0, 0, 0, 0},
         '{RowSource, "a", 0, 0, 0, 0, 0, 0},
         '{RowSource, "b", 1, 0, 0, 0, 0, 0}
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      foreach (rows[i]) begin
         if (rows[i].kind == RowCount) begin
            write_count(CountW'(rows[i].value));
         end else begin
            send_word(rows[i].kind == RowKeyword ? ActKeyword : ActSource, rows[i].value,
                      rows[i].eos, rows[i].slot, rows[i].pos, rows[i].wlen, made);
            if (rows[i].has_cls && made == 1 && pending_tokens[$].cls !== rows[i].cls)
               report("class table", pending_tokens[$].cls, rows[i].cls);
         end
      end

      // Random phases, each opened by a count write.
      while (items_sent < ItemTarget) begin
         v = usable_slots();
         if ($urandom_range(0, 99) < 15) cnt = '0;
         else if (v == KwSlots && $urandom_range(0, 1))
            cnt = CountW'($urandom_range(0, 1) ? 31 : 16);
         else cnt = CountW'($urandom_range(0, v));
         write_count(cnt);
         quiet = ($urandom_range(0, 99) < 20);
         for (int w = 0; w < 40 && items_sent < ItemTarget; w++) begin
            if ($urandom_range(0, 99) < 30) begin
               random_keyword_write();
               continue;
            end
            src_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                   : $urandom_range(1, 12);
            for (int b = 0; b < src_len; b++) begin
               if (b > 0 && $urandom_range(0, 99) < 6) random_keyword_write();
               send_word(ActSource, lex_byte(), b == src_len - 1, 0, 0, 0, made);
            end
         end
         quiet = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      $display("Covered %0d input words: %0d keyword writes, %0d sources.",
               items_sent, kw_writes, sources_done);
      $display("Checked %0d tokens, %0d of them keyword matches.", tokens_seen, words_seen);
      if (errors == 0) begin
         $display("keyword_and_char_class_lexer: match");
      end else begin
         $display("keyword_and_char_class_lexer: mismatch");
      end
      $finish;
   end

endmodule

// ----- keyword_and_char_class_lexer.f -----
rtl/kcl_pkg.sv
rtl/kcl_ram.sv
rtl/keyword_and_char_class_lexer.sv
bench/keyword_and_char_class_lexer_tb.sv
